// ----- design/wbs_pkg.sv -----
// Package for the word break segmenter: sizes, item kinds and the dictionary row layout.
// No dependencies; wbs_in_if and word_break_segmenter import it.
package wbs_pkg;

    localparam int MAX_WORDS    = 64;
    localparam int MAX_WORD_LEN = 32;

    localparam int CHAR_W     = 8;
    localparam int WORD_IDX_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int CNT_W      = $clog2(MAX_WORDS + 1);
    localparam int LEN_W      = $clog2(MAX_WORD_LEN + 1);
    localparam int HIST_W     = MAX_WORD_LEN + 1;
    localparam int HIST_IDX_W = $clog2(HIST_W);

    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_WORD   = 2'd1,
        KIND_TEXT   = 2'd2,
        KIND_UNUSED = 2'd3
    } t_kind;

    typedef logic [MAX_WORD_LEN-1:0][CHAR_W-1:0] t_chars;

    // Chars held newest first: index 0 is the word's final character.
    typedef struct packed {
        t_chars           chars;
        logic [LEN_W-1:0] len;
    } t_dict_row;

    localparam int ROW_W = $bits(t_dict_row);

endpackage

// ----- design/wbs_in_if.sv -----
// Input channel of the word break segmenter: valid/ready plus kind, ch and last.
// Depends on wbs_pkg.
interface wbs_in_if;
    import wbs_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [CHAR_W-1:0] ch;
    logic              last;

    modport source (output valid, kind, ch, last, input ready);
    modport sink   (input valid, kind, ch, last, output ready);
endinterface

// ----- design/wbs_out_if.sv -----
// Result channel of the word break segmenter: valid/ready plus segmentable and text_end.
// No dependencies.
interface wbs_out_if;
    logic valid;
    logic ready;
    logic segmentable;
    logic text_end;

    modport source (output valid, segmentable, text_end, input ready);
    modport sink   (input valid, segmentable, text_end, output ready);
endinterface

// ----- design/word_break_segmenter.sv -----
// Top level of the word break segmenter: load path, dictionary RAM and the word scan sequencer.
// Depends on wbs_pkg, wbs_in_if, wbs_out_if and wbs_ram.

// Clear and dictionary-character beats leave the sequencer idle. A text-character beat
// runs the scan and drain states while the dictionary holds words and goes straight to
// the emit state with an empty one: the sequencer reads one dictionary row per cycle
// from the single read port of the row RAM and checks the whole word against the recent
// text in one compare unit, then uses the drain state for the last compare and the emit
// state for issuing the result.
// Words are held in a 32-byte load buffer and written as a row on their final
// character, so a word is usable once complete. Input ready is low while a text
// character is being scanned; the result waits in an output register.
module word_break_segmenter (
    input  logic  i_clk,
    input  logic  i_rst_n,
    wbs_in_if.sink    i_in,
    wbs_out_if.source o_out
);
    import wbs_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_EMIT  = 4'b1000
    } t_state;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [LEN_W-1:0]      r_pos, n_pos;
    logic                  r_ovl, n_ovl;
    t_chars                r_ldbuf, n_ldbuf;
    t_chars                r_recent, n_recent;
    logic [HIST_W-1:0]     r_hist, n_hist;
    logic [WORD_IDX_W-1:0] r_w, n_w;
    logic                  r_cmp_vld, n_cmp_vld;
    logic                  r_hit, n_hit;
    logic                  r_text_last, n_text_last;
    logic                  r_out_valid, n_out_valid;
    logic                  r_out_seg, n_out_seg;
    logic                  r_out_end, n_out_end;

    logic                  accept;
    logic                  dict_full;
    logic                  ram_we;
    t_dict_row             wr_row;
    t_dict_row             rd_row;
    logic [ROW_W-1:0]      rd_data;
    logic                  rd_en;
    logic [HIST_IDX_W-1:0] len_m1;
    logic [MAX_WORD_LEN-1:0] char_ok;
    logic                  word_match;

    assign i_in.ready   = (r_state == ST_IDLE);
    assign accept       = i_in.valid && i_in.ready;
    assign dict_full    = (r_count == CNT_W'(MAX_WORDS));
    assign rd_en        = (r_state == ST_SCAN);

    assign o_out.valid       = r_out_valid;
    assign o_out.segmentable = r_out_seg;
    assign o_out.text_end    = r_out_end;

    wbs_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_WORDS)
    ) u_dict_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[WORD_IDX_W-1:0]),
        .i_wdata (wr_row),
        .i_re    (rd_en),
        .i_raddr (r_w),
        .o_rdata (rd_data)
    );

    // Word/text compare unit, one stored row per cycle
    always_comb begin
        rd_row = t_dict_row'(rd_data);
        len_m1 = HIST_IDX_W'(rd_row.len - LEN_W'(1));
        for (int k = 0; k < MAX_WORD_LEN; k++) begin
            char_ok[k] = (rd_row.chars[k] == r_recent[k]) || (LEN_W'(k) >= rd_row.len);
        end
        word_match = (rd_row.len != '0) && r_hist[len_m1] && (&char_ok);
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pos       = r_pos;
        n_ovl       = r_ovl;
        n_ldbuf     = r_ldbuf;
        n_recent    = r_recent;
        n_hist      = r_hist;
        n_w         = r_w;
        n_cmp_vld   = (r_state == ST_SCAN);
        n_hit       = r_hit | (r_cmp_vld & word_match);
        n_text_last = r_text_last;
        n_out_valid = r_out_valid & ~o_out.ready;
        n_out_seg   = r_out_seg;
        n_out_end   = r_out_end;
        ram_we      = 1'b0;
        wr_row      = '0;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_in.kind)
                        KIND_CLEAR: begin
                            n_count = '0;
                            n_pos   = '0;
                            n_ovl   = 1'b0;
                        end
                        KIND_WORD: begin
                            if (!dict_full) begin
                                if (r_pos < LEN_W'(MAX_WORD_LEN)) begin
                                    for (int k = MAX_WORD_LEN - 1; k > 0; k--) begin
                                        n_ldbuf[k] = r_ldbuf[k-1];
                                    end
                                    n_ldbuf[0] = i_in.ch;
                                    n_pos      = r_pos + LEN_W'(1);
                                end else begin
                                    n_ovl = 1'b1;
                                end
                            end
                            if (i_in.last) begin
                                if (!dict_full && !n_ovl && n_pos != '0) begin
                                    ram_we       = 1'b1;
                                    wr_row.chars = n_ldbuf;
                                    wr_row.len   = n_pos;
                                    n_count      = r_count + CNT_W'(1);
                                end
                                n_pos = '0;
                                n_ovl = 1'b0;
                            end
                        end
                        KIND_TEXT: begin
                            for (int k = MAX_WORD_LEN - 1; k > 0; k--) begin
                                n_recent[k] = r_recent[k-1];
                            end
                            n_recent[0] = i_in.ch;
                            n_text_last = i_in.last;
                            n_hit       = 1'b0;
                            n_w         = '0;
                            n_state     = (r_count == '0) ? ST_EMIT : ST_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                n_w = r_w + WORD_IDX_W'(1);
                if ((CNT_W'(r_w) + CNT_W'(1)) == r_count) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_seg   = r_hit;
                    n_out_end   = r_text_last;
                    if (r_text_last) begin
                        n_hist = HIST_W'(1);
                    end else begin
                        n_hist = {r_hist[HIST_W-2:0], r_hit};
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_pos       <= '0;
            r_ovl       <= 1'b0;
            r_hist      <= HIST_W'(1);
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pos       <= n_pos;
            r_ovl       <= n_ovl;
            r_hist      <= n_hist;
            r_cmp_vld   <= n_cmp_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ldbuf     <= n_ldbuf;
        r_recent    <= n_recent;
        r_w         <= n_w;
        r_hit       <= n_hit;
        r_text_last <= n_text_last;
        r_out_seg   <= n_out_seg;
        r_out_end   <= n_out_end;
    end

endmodule

// ----- design/wbs_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module wbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- tb/word_break_segmenter_tb.sv -----
// Self-checking testbench for word_break_segmenter: loads dictionaries and streams texts
// through the valid/ready channels, predicting each reachability bit in a scoreboard class.
// Depends on wbs_pkg, wbs_in_if, wbs_out_if and the word_break_segmenter RTL.
module word_break_segmenter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wbs_pkg::*;

    typedef struct packed {
        logic segmentable;
        logic text_end;
    } t_reach_result;

    // Tracks the dictionary and the text window; queues the expected bit for each text beat.
    class reach_tracker;
        logic [CHAR_W-1:0] dict_chars [MAX_WORDS][MAX_WORD_LEN];
        int                word_len [MAX_WORDS];
        int                n_words;
        int                load_pos;
        bit                load_over;
        logic [CHAR_W-1:0] recent [MAX_WORD_LEN];
        logic [HIST_W-1:0] reach_hist;
        t_reach_result     pending_reach [$];
        int                errors;

        function new();
            n_words   = 0;
            load_pos  = 0;
            load_over = 1'b0;
            errors    = 0;
            restart_text();
        endfunction

        function void restart_text();
            foreach (recent[i]) recent[i] = '0;
            reach_hist = HIST_W'(1);
        endfunction

        function bit word_hits(int w);
            int len;
            len = word_len[w];
            if (!reach_hist[len-1]) return 1'b0;
            for (int j = 0; j < len; j++)
                if (dict_chars[w][j] != recent[len-1-j]) return 1'b0;
            return 1'b1;
        endfunction

        function void absorb_beat(t_kind k, logic [CHAR_W-1:0] c, logic fin);
            bit            hit;
            t_reach_result res;
            hit = 1'b0;
            case (k)
                KIND_CLEAR: begin
                    n_words   = 0;
                    load_pos  = 0;
                    load_over = 1'b0;
                end
                KIND_WORD: begin
                    if (n_words < MAX_WORDS) begin
                        if (load_pos < MAX_WORD_LEN) begin
                            dict_chars[n_words][load_pos] = c;
                            load_pos++;
                        end else begin
                            load_over = 1'b1;
                        end
                    end
                    if (fin) begin
                        if (n_words < MAX_WORDS && !load_over && load_pos > 0) begin
                            word_len[n_words] = load_pos;
                            n_words++;
                        end
                        load_pos  = 0;
                        load_over = 1'b0;
                    end
                end
                KIND_TEXT: begin
                    for (int i = MAX_WORD_LEN - 1; i > 0; i--) recent[i] = recent[i-1];
                    recent[0] = c;
                    for (int w = 0; w < n_words && !hit; w++) hit = word_hits(w);
                    reach_hist = {reach_hist[HIST_W-2:0], hit};
                    res.segmentable = hit;
                    res.text_end    = fin;
                    pending_reach = {pending_reach, res};
                    if (fin) restart_text();
                end
                default: ;
            endcase
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $time, what);
            errors++;
        endtask

        task check_reach(logic seg, logic te);
            t_reach_result want;
            if (pending_reach.size() == 0) begin
                report($sformatf("unexpected result segmentable=%b text_end=%b", seg, te));
                return;
            end
            want = pending_reach.pop_front();
            if (seg !== want.segmentable)
                report($sformatf("segmentable %b, expected %b", seg, want.segmentable));
            if (te !== want.text_end)
                report($sformatf("text_end %b, expected %b", te, want.text_end));
        endtask

        task check_drained();
            if (pending_reach.size() != 0)
                report($sformatf("%0d results never arrived", pending_reach.size()));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   idle_on = 1'b1;
    int   n_beats = 0;
    logic [CHAR_W-1:0] alpha [3];

    reach_tracker tracker = new();

    wbs_in_if  in_if ();
    wbs_out_if out_if ();

    word_break_segmenter u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [CHAR_W-1:0] pick_char();
        if ($urandom_range(0, 9) == 0) return CHAR_W'($urandom_range(0, 255));
        return alpha[$urandom_range(0, 2)];
    endfunction

    task automatic send_beat(input t_kind k, input logic [CHAR_W-1:0] c, input logic fin);
        int gap;
        gap = idle_on ? $urandom_range(0, 8) : 0;
        @(negedge clk);
        if (gap > 0) begin
            in_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_if.valid = 1'b1;
        in_if.kind  = k;
        in_if.ch    = c;
        in_if.last  = fin;
        do @(posedge clk); while (!in_if.ready);
        tracker.absorb_beat(k, c, fin);
        if (k != KIND_UNUSED) n_beats++;
    endtask

    task automatic load_word(input int len);
        for (int j = 0; j < len; j++) send_beat(KIND_WORD, pick_char(), j == len - 1);
    endtask

    // Mostly concatenations of stored words, with stray characters and loads mixed in.
    task automatic send_text();
        int nparts;
        int w;
        int wl;
        logic [CHAR_W-1:0] wchars [MAX_WORD_LEN];
        nparts = $urandom_range(1, 10);
        for (int p = 0; p < nparts; p++) begin
            if (tracker.n_words > 0 && $urandom_range(0, 4) != 0) begin
                w  = $urandom_range(0, tracker.n_words - 1);
                wl = tracker.word_len[w];
                for (int j = 0; j < wl; j++) wchars[j] = tracker.dict_chars[w][j];
                for (int j = 0; j < wl; j++)
                    send_beat(KIND_TEXT, wchars[j], p == nparts - 1 && j == wl - 1);
            end else begin
                send_beat(KIND_TEXT, pick_char(), p == nparts - 1);
            end
            if (p != nparts - 1 && $urandom_range(0, 19) == 0)
                send_beat(KIND_WORD, pick_char(), 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 29) == 0)
                send_beat(KIND_UNUSED, CHAR_W'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
        end
    endtask

    initial begin : stimulus
        int  nw;
        int  len;
        int  r;
        bit  fill;
        in_if.valid = 1'b0;
        in_if.kind  = KIND_CLEAR;
        in_if.ch    = '0;
        in_if.last  = 1'b0;
        rst_n       = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_beat(KIND_UNUSED, 8'hAA, 1'b1);
        send_beat(KIND_TEXT,   8'h00, 1'b1);
        send_beat(KIND_WORD,   8'h00, 1'b1);
        send_beat(KIND_WORD,   8'hFF, 1'b0);
        send_beat(KIND_WORD,   8'hFF, 1'b1);
        send_beat(KIND_TEXT,   8'hFF, 1'b0);
        send_beat(KIND_TEXT,   8'hFF, 1'b0);
        send_beat(KIND_TEXT,   8'h00, 1'b0);
        // word still being loaded must not match
        send_beat(KIND_WORD,   8'h41, 1'b0);
        send_beat(KIND_TEXT,   8'h41, 1'b0);
        send_beat(KIND_WORD,   8'h42, 1'b1);
        send_beat(KIND_TEXT,   8'h42, 1'b1);
        send_beat(KIND_TEXT,   8'h42, 1'b1);
        send_beat(KIND_CLEAR,  8'hFF, 1'b1);
        send_beat(KIND_TEXT,   8'h00, 1'b1);
        send_beat(KIND_WORD,   8'h5A, 1'b1);
        send_beat(KIND_UNUSED, 8'h55, 1'b0);
        send_beat(KIND_TEXT,   8'h5A, 1'b0);
        send_beat(KIND_TEXT,   8'h5A, 1'b1);

        while (n_beats < 1000) begin
            idle_on = ($urandom_range(0, 4) != 0);
            foreach (alpha[i]) alpha[i] = CHAR_W'($urandom_range(0, 255));
            if ($urandom_range(0, 3) == 0)
                send_beat(KIND_CLEAR, CHAR_W'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
            fill = ($urandom_range(0, 9) == 0);
            nw   = fill ? $urandom_range(66, 72) : $urandom_range(0, 5);
            for (int i = 0; i < nw; i++) begin
                r = $urandom_range(0, 99);
                if (fill)        len = $urandom_range(1, 2);
                else if (r < 80) len = $urandom_range(1, 4);
                else if (r < 93) len = $urandom_range(28, MAX_WORD_LEN);
                else             len = $urandom_range(MAX_WORD_LEN + 1, MAX_WORD_LEN + 4);
                load_word(len);
            end
            r = $urandom_range(1, 4);
            for (int t = 0; t < r; t++) send_text();
        end

        @(negedge clk);
        in_if.valid = 1'b0;
        while (tracker.pending_reach.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        tracker.check_drained();
        if (tracker.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin : result_sink
        int gap;
        int taken;
        taken        = 0;
        out_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            // long hold-offs so the output register fills and input stalls
            if (taken == 40 || taken == 400) begin
                out_if.ready = 1'b0;
                repeat (300) @(negedge clk);
            end
            gap = idle_on ? $urandom_range(0, 8) : 0;
            if (gap > 0) begin
                out_if.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_if.ready = 1'b1;
            do @(posedge clk); while (!out_if.valid);
            tracker.check_reach(out_if.segmentable, out_if.text_end);
            taken++;
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
